[rtl/core/lfp_pkg.sv]
// lfp_pkg: shared types and constants of the lidar frame parser
// used by lfp_status and lidar_frame_parser_top; no dependencies
`default_nettype none

package lfp_pkg;

    localparam logic [7:0]  HEADER_BYTE    = 8'h59;
    localparam logic [2:0]  LAST_DATA_IDX  = 3'd5;
    localparam logic [15:0] DIST_LOW_STR   = 16'hFFFF;
    localparam logic [15:0] DIST_SAT_STR   = 16'hFFFE;
    localparam logic [15:0] DIST_AMB_SAT   = 16'hFFFC;
    localparam logic [15:0] STRENGTH_SAT   = 16'hFFFF;
    localparam logic [13:0] TEMP_OFFSET    = 14'd256;

    localparam logic [15:0] STRENGTH_FLOOR_RST = 16'd100;
    localparam logic [13:0] TEMP_LOW_RST       = 14'd0;
    localparam logic [13:0] TEMP_HIGH_RST      = 14'd70;

    // frame status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_LOW_STRENGTH = 3'd1;
    localparam logic [2:0] ST_SAT_STRENGTH = 3'd2;
    localparam logic [2:0] ST_AMB_SAT      = 3'd3;
    localparam logic [2:0] ST_TEMP         = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_STRENGTH_FLOOR = 2'd0;
    localparam logic [1:0] REG_TEMP_LOW       = 2'd1;
    localparam logic [1:0] REG_TEMP_HIGH      = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT_FIRST  = 2'd0,
        PH_HUNT_SECOND = 2'd1,
        PH_PAYLOAD     = 2'd2
    } phase_t;

    typedef struct packed {
        logic [15:0]        strength_floor;
        logic signed [13:0] temp_low;
        logic signed [13:0] temp_high;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/core/lfp_status.sv]
// lfp_status: temperature conversion and status priority of one frame
// depends on lfp_pkg
`default_nettype none

module lfp_status (
    input  wire logic [15:0]        distance_word,
    input  wire logic [15:0]        strength_word,
    input  wire logic [15:0]        temp_word,
    input  wire lfp_pkg::cfg_t      cfg,
    output logic signed [13:0]      temperature_c,
    output logic [2:0]              frame_status
);

    // raw / 8 fits in 13 bits, so the offset result fits 14 signed bits
    assign temperature_c = $signed({1'b0, temp_word[15:3]} - lfp_pkg::TEMP_OFFSET);

    always_comb
    begin
        if (distance_word == lfp_pkg::DIST_LOW_STR ||
            strength_word < cfg.strength_floor)
        begin
            frame_status = lfp_pkg::ST_LOW_STRENGTH;
        end
        else if (distance_word == lfp_pkg::DIST_SAT_STR ||
                 strength_word == lfp_pkg::STRENGTH_SAT)
        begin
            frame_status = lfp_pkg::ST_SAT_STRENGTH;
        end
        else if (distance_word == lfp_pkg::DIST_AMB_SAT)
        begin
            frame_status = lfp_pkg::ST_AMB_SAT;
        end
        else if (temperature_c < cfg.temp_low || temperature_c > cfg.temp_high)
        begin
            frame_status = lfp_pkg::ST_TEMP;
        end
        else
        begin
            frame_status = lfp_pkg::ST_OK;
        end
    end

endmodule

`default_nettype wire

[rtl/core/lidar_frame_parser_top.sv]
// lidar_frame_parser_top: byte-wise parser for nine-byte lidar serial frames
// depends on lfp_pkg and lfp_status
//
// usage:
//   s_* is the byte stream from the serial receiver, one byte per request in
//   s_tdata. m_* carries one result per frame that passes its checksum;
//   frames with a bad checksum give nothing. cfg_wr_en/cfg_index/cfg_wdata
//   write strength_floor (0), temp_low (1) and temp_high (2); other indexes
//   are ignored.
//   a byte is registered in the input register when accepted and decoded
//   from there into the result register, which raises m_tvalid for a frame
//   once its checksum byte is decoded. one byte per cycle is taken in steady
//   flow while the result register is not stalled; the rate is set by the
//   single decode stage between the input register and the result register.
//   when the receiver stalls with a result waiting, the decode stage holds
//   and an empty input register still takes one more byte; once it holds a
//   byte s_tready drops until the result is taken.
//   reset clears the hunt state, both pipeline valids and loads the register
//   defaults (floor 100, temperature window 0 to 70).
`default_nettype none

module lidar_frame_parser_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] range_cm, [31:16] strength, [45:32] temperature_c,
    // [48:46] frame_status, [55:49] zero
    output logic [55:0]      m_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    lfp_pkg::cfg_t   cfg_reg;

    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;

    lfp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]      idx_reg, idx_next;
    logic [7:0]      sum_reg, sum_next;
    logic [15:0]     dist_reg, dist_next;
    logic [15:0]     str_reg, str_next;
    logic [15:0]     tw_reg, tw_next;

    logic            out_valid_reg;
    logic [15:0]     out_dist_reg;
    logic [15:0]     out_str_reg;
    logic [13:0]     out_temp_reg;
    logic [2:0]      out_status_reg;

    logic            advance;
    logic            step;
    logic            frame_good;
    logic signed [13:0] temp_c;
    logic [2:0]      status;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.strength_floor <= lfp_pkg::STRENGTH_FLOOR_RST;
            cfg_reg.temp_low       <= lfp_pkg::TEMP_LOW_RST;
            cfg_reg.temp_high      <= lfp_pkg::TEMP_HIGH_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lfp_pkg::REG_STRENGTH_FLOOR: cfg_reg.strength_floor <= cfg_wdata;
                lfp_pkg::REG_TEMP_LOW:       cfg_reg.temp_low  <= $signed(cfg_wdata[13:0]);
                lfp_pkg::REG_TEMP_HIGH:      cfg_reg.temp_high <= $signed(cfg_wdata[13:0]);
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        dist_next  = dist_reg;
        str_next   = str_reg;
        tw_next    = tw_reg;
        unique case (phase_reg)
            lfp_pkg::PH_HUNT_SECOND:
            begin
                if (in_byte_reg == lfp_pkg::HEADER_BYTE)
                begin
                    phase_next = lfp_pkg::PH_PAYLOAD;
                    idx_next   = 3'd0;
                    sum_next   = lfp_pkg::HEADER_BYTE + lfp_pkg::HEADER_BYTE;
                end
                else
                begin
                    phase_next = lfp_pkg::PH_HUNT_FIRST;
                end
            end
            lfp_pkg::PH_PAYLOAD:
            begin
                if (idx_reg <= lfp_pkg::LAST_DATA_IDX)
                begin
                    sum_next = sum_reg + in_byte_reg;
                    idx_next = idx_reg + 3'd1;
                    case (idx_reg)
                        3'd0:    dist_next[7:0]  = in_byte_reg;
                        3'd1:    dist_next[15:8] = in_byte_reg;
                        3'd2:    str_next[7:0]   = in_byte_reg;
                        3'd3:    str_next[15:8]  = in_byte_reg;
                        3'd4:    tw_next[7:0]    = in_byte_reg;
                        default: tw_next[15:8]   = in_byte_reg;
                    endcase
                end
                else
                begin
                    // checksum byte closes the frame either way
                    phase_next = lfp_pkg::PH_HUNT_FIRST;
                    idx_next   = 3'd0;
                end
            end
            default:
            begin
                phase_next = (in_byte_reg == lfp_pkg::HEADER_BYTE) ?
                             lfp_pkg::PH_HUNT_SECOND : lfp_pkg::PH_HUNT_FIRST;
            end
        endcase
    end

    // result decode
    always_comb
    begin
        frame_good = (phase_reg == lfp_pkg::PH_PAYLOAD) &&
                     (idx_reg > lfp_pkg::LAST_DATA_IDX) &&
                     (in_byte_reg == sum_reg);
    end

    lfp_status u_status (
        .distance_word (dist_reg),
        .strength_word (str_reg),
        .temp_word     (tw_reg),
        .cfg           (cfg_reg),
        .temperature_c (temp_c),
        .frame_status  (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lfp_pkg::PH_HUNT_FIRST;
            idx_reg   <= 3'd0;
            sum_reg   <= 8'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            dist_reg <= dist_next;
            str_reg  <= str_next;
            tw_reg   <= tw_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && frame_good;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && frame_good)
        begin
            out_dist_reg   <= dist_reg;
            out_str_reg    <= str_reg;
            out_temp_reg   <= temp_c;
            out_status_reg <= status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_status_reg, out_temp_reg, out_str_reg, out_dist_reg};

    // assertions
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= 3'd6)
        else $error("payload index beyond checksum byte");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (step && frame_good) |=> (phase_reg == lfp_pkg::PH_HUNT_FIRST && idx_reg == 3'd0))
        else $error("parser did not return to header hunt after a frame");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("buffered byte lost while result stalled");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(phase_reg == lfp_pkg::PH_PAYLOAD && step))
        else $error("result without a checksum byte");

endmodule

`default_nettype wire

[tb/lfp_tb_pkg.sv]
`timescale 1ns / 1ps
// lfp_tb_pkg: frame tracker for the lidar frame parser testbench
// predicts decoded frames from accepted bytes; depends on lfp_pkg
package lfp_tb_pkg;

    import lfp_pkg::*;

    typedef struct {
        logic [15:0]        range_cm;
        logic [15:0]        strength;
        logic signed [13:0] temperature_c;
        logic [2:0]         frame_status;
    } frame_result_t;

    class frame_scoreboard;
        phase_t        phase;
        logic [2:0]    byte_idx;
        logic [7:0]    run_sum;
        logic [15:0]   dist_w;
        logic [15:0]   str_w;
        logic [15:0]   raw_temp_w;
        cfg_t          cfg;
        frame_result_t pending_frames[$];
        int            errors;
        int            frames_checked;
        int            frames_dropped;

        function new();
            phase              = PH_HUNT_FIRST;
            byte_idx           = '0;
            run_sum            = '0;
            dist_w             = '0;
            str_w              = '0;
            raw_temp_w         = '0;
            cfg.strength_floor = STRENGTH_FLOOR_RST;
            cfg.temp_low       = TEMP_LOW_RST;
            cfg.temp_high      = TEMP_HIGH_RST;
            errors             = 0;
            frames_checked     = 0;
            frames_dropped     = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                REG_STRENGTH_FLOOR: cfg.strength_floor = value;
                REG_TEMP_LOW:       cfg.temp_low = value[13:0];
                REG_TEMP_HIGH:      cfg.temp_high = value[13:0];
                default: ;
            endcase
        endfunction

        function frame_result_t decode_frame();
            frame_result_t r;
            r.range_cm      = dist_w;
            r.strength      = str_w;
            r.temperature_c = {1'b0, raw_temp_w[15:3]} - TEMP_OFFSET;
            // status checks in priority order
            if (dist_w == DIST_LOW_STR || str_w < cfg.strength_floor)
                r.frame_status = ST_LOW_STRENGTH;
            else if (dist_w == DIST_SAT_STR || str_w == STRENGTH_SAT)
                r.frame_status = ST_SAT_STRENGTH;
            else if (dist_w == DIST_AMB_SAT)
                r.frame_status = ST_AMB_SAT;
            else if (r.temperature_c < cfg.temp_low || r.temperature_c > cfg.temp_high)
                r.frame_status = ST_TEMP;
            else
                r.frame_status = ST_OK;
            return r;
        endfunction

        function void note_byte(logic [7:0] b);
            case (phase)
                PH_HUNT_SECOND:
                begin
                    if (b == HEADER_BYTE)
                    begin
                        phase    = PH_PAYLOAD;
                        byte_idx = '0;
                        run_sum  = HEADER_BYTE + HEADER_BYTE;
                    end
                    else
                        phase = PH_HUNT_FIRST;
                end
                PH_PAYLOAD:
                begin
                    if (byte_idx <= LAST_DATA_IDX)
                    begin
                        run_sum = run_sum + b;
                        case (byte_idx)
                            3'd0:    dist_w[7:0]      = b;
                            3'd1:    dist_w[15:8]     = b;
                            3'd2:    str_w[7:0]       = b;
                            3'd3:    str_w[15:8]      = b;
                            3'd4:    raw_temp_w[7:0]  = b;
                            default: raw_temp_w[15:8] = b;
                        endcase
                        byte_idx = byte_idx + 3'd1;
                    end
                    else
                    begin
                        // checksum byte closes the frame either way
                        phase    = PH_HUNT_FIRST;
                        byte_idx = '0;
                        if (b == run_sum)
                            pending_frames.push_back(decode_frame());
                        else
                            frames_dropped++;
                    end
                end
                default:
                begin
                    if (b == HEADER_BYTE)
                        phase = PH_HUNT_SECOND;
                    else
                        phase = PH_HUNT_FIRST;
                end
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [55:0] data);
            frame_result_t want;
            if (pending_frames.size() == 0)
            begin
                $display("%0t: result with no frame pending, expected none, actual %h",
                         $time, data);
                errors++;
                return;
            end
            want = pending_frames.pop_front();
            frames_checked++;
            compare_field("range_cm", want.range_cm, data[15:0]);
            compare_field("strength", want.strength, data[31:16]);
            compare_field("temperature_c", {2'b00, want.temperature_c}, {2'b00, data[45:32]});
            compare_field("frame_status", {13'b0, want.frame_status}, {13'b0, data[48:46]});
            compare_field("padding", 16'h0000, {9'b0, data[55:49]});
        endfunction

        function int pending();
            return pending_frames.size();
        endfunction
    endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: stream-level regression of lidar_frame_parser_top
// depends on lfp_pkg, lfp_tb_pkg and the parser rtl
module tb_top;

    import lfp_pkg::*;
    import lfp_tb_pkg::*;

    localparam int         HALF_PERIOD  = 4;
    localparam int         RESET_CYCLES = 10;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         IDLE_LIMIT   = 5000;
    localparam int         PHASE_BYTES  = 210;
    localparam logic [1:0] REG_UNUSED   = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    frame_scoreboard    frames;
    int                 bytes_sent;
    int                 settings_applied;
    int                 idle_cycles;
    int                 hold_cnt;
    bit                 rdy_next;
    bit                 no_idle;
    logic [15:0]        cur_floor;
    logic signed [13:0] cur_tlo;
    logic signed [13:0] cur_thi;

    lidar_frame_parser_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // receiver: runs of ready and stalls, mostly short
    always @(negedge clk)
    begin
        if (hold_cnt == 0)
        begin
            if (no_idle || $urandom_range(0, 99) < 55)
            begin
                rdy_next = 1'b1;
                hold_cnt = $urandom_range(1, 12);
            end
            else
            begin
                rdy_next = 1'b0;
                hold_cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 3);
            end
        end
        hold_cnt--;
        m_tready <= rdy_next;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            frames.check_result(m_tdata);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // raw sensor word for a temperature, random in the dropped low bits
    function automatic logic [15:0] raw_for_temp(int t);
        int c;
        c = t;
        if (c < -256)
            c = -256;
        if (c > 7935)
            c = 7935;
        return 16'(((c + 256) << 3) | int'($urandom_range(0, 7)));
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        frames.note_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [15:0] range_w, input logic [15:0] str,
                              input logic [15:0] raw, input bit good);
        logic [7:0] payload [6];
        logic [7:0] csum;
        payload = '{range_w[7:0], range_w[15:8], str[7:0], str[15:8], raw[7:0], raw[15:8]};
        csum    = HEADER_BYTE + HEADER_BYTE;
        send_byte(HEADER_BYTE);
        send_byte(HEADER_BYTE);
        foreach (payload[i])
        begin
            send_byte(payload[i]);
            csum = csum + payload[i];
        end
        if (!good)
            csum = csum + 8'($urandom_range(1, 255));
        send_byte(csum);
    endtask

    task automatic send_random_frame();
        logic [15:0] range_w;
        logic [15:0] str;
        logic [15:0] raw;
        case ($urandom_range(0, 9))
            0:       range_w = DIST_LOW_STR;
            1:       range_w = DIST_SAT_STR;
            2:       range_w = DIST_AMB_SAT;
            3:       range_w = {HEADER_BYTE, HEADER_BYTE};
            default: range_w = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       str = cur_floor - 16'd1;
            1:       str = cur_floor;
            2:       str = cur_floor + 16'd1;
            3:       str = STRENGTH_SAT;
            4:       str = 16'hFFFE;
            5:       str = 16'h0000;
            default: str = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       raw = raw_for_temp(int'(cur_tlo) - 1);
            1:       raw = raw_for_temp(int'(cur_tlo));
            2:       raw = raw_for_temp(int'(cur_thi));
            3:       raw = raw_for_temp(int'(cur_thi) + 1);
            4:       raw = 16'h0000;
            5:       raw = 16'hFFFF;
            6, 7:
            begin
                if (cur_tlo <= cur_thi)
                    raw = raw_for_temp(int'(cur_tlo) +
                                       int'($urandom_range(0, int'(cur_thi - cur_tlo))));
                else
                    raw = 16'($urandom);
            end
            default: raw = 16'($urandom);
        endcase
        send_frame(range_w, str, raw, $urandom_range(0, 99) < 85);
    endtask

    // stray bytes, broken headers and stacked headers
    task automatic send_noise();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0:
            begin
                repeat ($urandom_range(1, 5))
                    send_byte(8'($urandom));
            end
            1:
            begin
                b = 8'($urandom);
                if (b == HEADER_BYTE)
                    b = b ^ 8'h01;
                send_byte(HEADER_BYTE);
                send_byte(b);
            end
            2:
                send_byte(HEADER_BYTE);
            default:
            begin
                repeat (3)
                    send_byte(HEADER_BYTE);
            end
        endcase
    endtask

    task automatic run_random(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 80)
                send_random_frame();
            else
                send_noise();
        end
    endtask

    // bad-checksum frames leave nothing to wait for, so pad with DRAIN_CYCLES
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (frames.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        frames.set_reg(idx, value);
        @(negedge clk);
    endtask

    task automatic apply_config(input logic [15:0] floor, input logic signed [13:0] lo,
                                input logic signed [13:0] hi);
        write_reg(REG_STRENGTH_FLOOR, floor);
        // top bits lie outside the 14-bit registers
        write_reg(REG_TEMP_LOW, {2'($urandom), lo});
        write_reg(REG_TEMP_HIGH, {2'($urandom), hi});
        write_reg(REG_UNUSED, 16'($urandom));
        cfg_wr_en <= 1'b0;
        cur_floor = floor;
        cur_tlo   = lo;
        cur_thi   = hi;
        settings_applied++;
    endtask

    initial
    begin
        logic signed [13:0] lo;
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        m_tready         = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        bytes_sent       = 0;
        settings_applied = 0;
        idle_cycles      = 0;
        hold_cnt         = 0;
        rdy_next         = 1'b0;
        no_idle          = 1'b0;
        cur_floor        = STRENGTH_FLOOR_RST;
        cur_tlo          = TEMP_LOW_RST;
        cur_thi          = TEMP_HIGH_RST;
        frames           = new();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: floor 100, window 0 to 70
        send_frame(16'd1234, 16'd500, raw_for_temp(25), 1'b1);
        send_frame(16'd0, 16'd100, raw_for_temp(0), 1'b1);
        send_frame(16'hFFFD, 16'hFFFE, raw_for_temp(70), 1'b1);
        send_frame(DIST_LOW_STR, 16'd500, raw_for_temp(25), 1'b1);
        send_frame(16'd300, 16'd99, raw_for_temp(25), 1'b1);
        send_frame(DIST_SAT_STR, 16'd500, raw_for_temp(25), 1'b1);
        send_frame(16'd300, STRENGTH_SAT, raw_for_temp(25), 1'b1);
        send_frame(DIST_AMB_SAT, 16'd500, raw_for_temp(25), 1'b1);
        send_frame(16'd300, 16'd500, raw_for_temp(-1), 1'b1);
        send_frame(16'd300, 16'd500, raw_for_temp(71), 1'b1);
        send_frame(16'd300, 16'd500, 16'h0000, 1'b1);
        send_frame(16'd300, 16'd500, 16'hFFFF, 1'b1);
        // header bytes as payload data
        send_frame(16'h5959, 16'h5959, 16'h5959, 1'b1);
        send_frame(16'd300, 16'd500, raw_for_temp(25), 1'b0);
        // broken header, then a clean frame
        send_byte(HEADER_BYTE);
        send_byte(8'hA5);
        send_frame(16'd42, 16'd4242, raw_for_temp(40), 1'b1);
        // extra header byte shifts the frame by one
        send_byte(HEADER_BYTE);
        send_frame(16'd77, 16'd777, raw_for_temp(30), 1'b1);

        wait_idle();
        apply_config(16'h0000, -14'sd256, 14'sd7935);
        run_random(PHASE_BYTES);

        wait_idle();
        apply_config(16'hFFFF, 14'sd7935, -14'sd256);
        run_random(PHASE_BYTES);

        wait_idle();
        no_idle = 1'b1;
        lo = 14'(int'($urandom_range(0, 120)) - 40);
        apply_config(16'($urandom_range(0, 2000)), lo, lo + 14'($urandom_range(0, 100)));
        run_random(PHASE_BYTES);

        wait_idle();
        no_idle = 1'b0;
        apply_config(STRENGTH_FLOOR_RST, TEMP_LOW_RST, TEMP_HIGH_RST);
        run_random(PHASE_BYTES);

        wait_idle();
        $display("sent %0d bytes under %0d register settings plus reset values",
                 bytes_sent, settings_applied);
        $display("%0d frames decoded and checked, %0d dropped on bad checksum, %0d errors",
                 frames.frames_checked, frames.frames_dropped, frames.errors);
        if (frames.errors == 0 && frames.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
